// ----- rtl/qevt_pkg.sv -----
// ---------------------------------------------------------------------------
// qevt_pkg: shared types and constants of the quadrature value tracker
// Holds the item, result and register structs, the register index codes,
// the quarter-step transition table and the range clamp function.
// ---------------------------------------------------------------------------
package qevt_pkg;

  localparam int unsigned CfgIndexW = 4;
  localparam int unsigned CfgDataW  = 16;

  // Register reset values
  localparam logic [6:0]  MinValueRst     = 7'd0;
  localparam logic [6:0]  MaxValueRst     = 7'd127;
  localparam logic [4:0]  SensitivityRst  = 5'd1;
  localparam logic [6:0]  InitialValueRst = 7'd0;
  localparam logic [15:0] MinTransUsRst   = 16'd250;
  localparam logic [7:0]  LockDebMsRst    = 8'd24;
  localparam logic [7:0]  LockSettleMsRst = 8'd30;

  // Last-sent marker meaning nothing has been read out yet
  localparam logic [7:0]  NoneSent = 8'hFF;

  typedef enum logic [CfgIndexW-1:0] {
    REG_MIN_VALUE      = 4'd0,
    REG_MAX_VALUE      = 4'd1,
    REG_SENSITIVITY    = 4'd2,
    REG_INITIAL_VALUE  = 4'd3,
    REG_LOCK_ENABLE    = 4'd4,
    REG_MIN_TRANS_US   = 4'd5,
    REG_LOCK_DEB_MS    = 4'd6,
    REG_LOCK_SETTLE_MS = 4'd7
  } qevt_reg_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_READ   = 1'b1
  } qevt_req_t;

  // Quarter-step codes
  localparam logic signed [1:0] Q_NONE = 2'sb00;
  localparam logic signed [1:0] Q_UP   = 2'sb01;
  localparam logic signed [1:0] Q_DOWN = 2'sb11;

  // Indexed by {last_phase, phase}, phase = {A, B}
  localparam logic signed [1:0] QTAB [16] = '{
    Q_NONE, Q_UP,   Q_DOWN, Q_NONE,
    Q_DOWN, Q_NONE, Q_NONE, Q_UP,
    Q_UP,   Q_NONE, Q_NONE, Q_DOWN,
    Q_NONE, Q_DOWN, Q_UP,   Q_NONE
  };

  typedef struct packed {
    logic [6:0]  min_value;
    logic [6:0]  max_value;
    logic [4:0]  sensitivity;
    logic [6:0]  initial_value;
    logic        lock_enable;
    logic [15:0] min_transition_us;
    logic [7:0]  lock_debounce_ms;
    logic [7:0]  lock_settle_ms;
  } qevt_cfg_t;

  typedef struct packed {
    qevt_req_t   req_type;
    logic        pin_a;
    logic        pin_b;
    logic        lock_low;
    logic [31:0] now_us;
    logic [31:0] now_ms;
  } qevt_item_t;

  typedef struct packed {
    logic       msg_valid;
    logic [6:0] msg_value;
    logic       pending_flag;
    logic       locked;
  } qevt_result_t;

  // Clamp a signed sum to [lo, hi]; below lo wins over above hi
  function automatic logic [6:0] qevt_clamp(logic signed [8:0] v,
                                            logic [6:0] lo, logic [6:0] hi);
    logic [6:0] r;
    if (v < $signed({2'b00, lo})) begin
      r = lo;
    end else if (v > $signed({2'b00, hi})) begin
      r = hi;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/qevt_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// qevt_cfg_regs: configuration register file
// Takes register writes and flags a bound change for an immediate re-clamp.
// ---------------------------------------------------------------------------
module qevt_cfg_regs import qevt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CfgIndexW-1:0] wr_index,
  input  logic [CfgDataW-1:0]  wr_data,
  output qevt_cfg_t            cfg,
  output logic                 range_upd
);

  qevt_cfg_t cfg_r;
  logic      range_upd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_value         <= MinValueRst;
      cfg_r.max_value         <= MaxValueRst;
      cfg_r.sensitivity       <= SensitivityRst;
      cfg_r.initial_value     <= InitialValueRst;
      cfg_r.lock_enable       <= 1'b0;
      cfg_r.min_transition_us <= MinTransUsRst;
      cfg_r.lock_debounce_ms  <= LockDebMsRst;
      cfg_r.lock_settle_ms    <= LockSettleMsRst;
      range_upd_r             <= 1'b0;
    end else begin
      // flag a bound write so the live value is pulled inside next cycle
      range_upd_r <= wr_en && (qevt_reg_t'(wr_index) == REG_MIN_VALUE ||
                               qevt_reg_t'(wr_index) == REG_MAX_VALUE);
      if (wr_en) begin
        unique case (qevt_reg_t'(wr_index))
          REG_MIN_VALUE:      cfg_r.min_value         <= wr_data[6:0];
          REG_MAX_VALUE:      cfg_r.max_value         <= wr_data[6:0];
          REG_SENSITIVITY:    cfg_r.sensitivity       <= wr_data[4:0];
          REG_INITIAL_VALUE:  cfg_r.initial_value     <= wr_data[6:0];
          REG_LOCK_ENABLE:    cfg_r.lock_enable       <= wr_data[0];
          REG_MIN_TRANS_US:   cfg_r.min_transition_us <= wr_data;
          REG_LOCK_DEB_MS:    cfg_r.lock_debounce_ms  <= wr_data[7:0];
          REG_LOCK_SETTLE_MS: cfg_r.lock_settle_ms    <= wr_data[7:0];
          default: ;  // drop writes beyond the register list
        endcase
      end
    end
  end

  assign cfg       = cfg_r;
  assign range_upd = range_upd_r;

endmodule

// ----- rtl/qevt_decode.sv -----
// ---------------------------------------------------------------------------
// qevt_decode: tracker state and single-pass step logic
// Holds decode, lock and value state; computes one item's result and the
// next state combinationally in a single pass.
// ---------------------------------------------------------------------------
module qevt_decode import qevt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  qevt_cfg_t    cfg,
  input  logic         range_upd,
  input  logic         step_en,
  input  qevt_item_t   item,
  output qevt_result_t result
);

  logic              started_r,    started_nxt;
  logic [1:0]        last_phase_r, last_phase_nxt;
  logic signed [1:0] acc_r,        acc_nxt;
  logic [6:0]        cur_value_r,  cur_value_nxt;
  logic [7:0]        last_sent_r,  last_sent_nxt;
  logic              pending_r,    pending_nxt;
  logic              lock_raw_r,   lock_raw_nxt;
  logic              lock_stable_r, lock_stable_nxt;
  logic [31:0]       lock_chg_r,   lock_chg_nxt;
  logic [31:0]       suppress_r,   suppress_nxt;
  logic [31:0]       last_us_r,    last_us_nxt;
  logic              blocked_r,    blocked_nxt;

  logic [6:0]        base_cur;
  logic [6:0]        cur_eff;
  logic [1:0]        phase;
  logic [31:0]       ms_diff;
  logic [31:0]       us_diff;
  logic              go;
  logic signed [1:0] q;
  logic [4:0]        s_eff;
  logic signed [8:0] sum;
  logic              msg_valid;

  always_comb begin
    started_nxt     = started_r;
    last_phase_nxt  = last_phase_r;
    acc_nxt         = acc_r;
    last_sent_nxt   = last_sent_r;
    pending_nxt     = pending_r;
    lock_raw_nxt    = lock_raw_r;
    lock_stable_nxt = lock_stable_r;
    lock_chg_nxt    = lock_chg_r;
    suppress_nxt    = suppress_r;
    last_us_nxt     = last_us_r;
    blocked_nxt     = blocked_r;
    msg_valid       = 1'b0;
    phase           = {item.pin_a, item.pin_b};
    ms_diff         = '0;
    us_diff         = item.now_us - last_us_r;
    go              = 1'b1;
    q               = QTAB[{last_phase_r, phase}];
    s_eff           = (cfg.sensitivity == 5'd0) ? 5'd1 : cfg.sensitivity;
    sum             = '0;

    // re-clamp right after a bound write
    base_cur = (range_upd && started_r)
             ? qevt_clamp($signed({2'b00, cur_value_r}), cfg.min_value, cfg.max_value)
             : cur_value_r;
    cur_eff  = started_r ? base_cur
             : qevt_clamp($signed({2'b00, cfg.initial_value}), cfg.min_value,
                          cfg.max_value);
    cur_value_nxt = cur_eff;

    if (step_en) begin
      if (item.req_type == REQ_READ) begin
        if (pending_r) begin
          msg_valid     = 1'b1;
          last_sent_nxt = {1'b0, cur_eff};
          pending_nxt   = 1'b0;
        end
      end else if (!started_r) begin
        // capture only
        started_nxt     = 1'b1;
        last_phase_nxt  = phase;
        acc_nxt         = Q_NONE;
        lock_raw_nxt    = item.lock_low;
        lock_stable_nxt = item.lock_low;
        lock_chg_nxt    = item.now_ms;
        suppress_nxt    = '0;
        last_us_nxt     = item.now_us;
        blocked_nxt     = 1'b0;
      end else begin
        blocked_nxt = 1'b0;
        if (cfg.lock_enable) begin
          lock_raw_nxt = item.lock_low;
          if (item.lock_low != lock_raw_r) begin
            lock_chg_nxt = item.now_ms;
          end
          ms_diff = item.now_ms - lock_chg_nxt;
          if (ms_diff >= {24'd0, cfg.lock_debounce_ms} &&
              lock_stable_r != item.lock_low) begin
            lock_stable_nxt = item.lock_low;
            if (lock_stable_r && !item.lock_low) begin
              suppress_nxt = item.now_ms + {24'd0, cfg.lock_settle_ms};
            end
          end
          if (lock_stable_nxt || item.now_ms < suppress_nxt) begin
            last_phase_nxt = phase;
            acc_nxt        = Q_NONE;
            blocked_nxt    = 1'b1;
            go             = 1'b0;
          end
        end
        if (go && phase != last_phase_r) begin
          last_phase_nxt = phase;
          if (us_diff >= {16'd0, cfg.min_transition_us}) begin
            last_us_nxt = item.now_us;
            if (q == Q_NONE) begin
              acc_nxt = Q_NONE;
            end else if (acc_r == q) begin
              // second quarter-step the same way: move one detent
              acc_nxt = Q_NONE;
              if (q == Q_UP) begin
                sum = $signed({2'b00, cur_eff}) + $signed({4'b0000, s_eff});
              end else begin
                sum = $signed({2'b00, cur_eff}) - $signed({4'b0000, s_eff});
              end
              cur_value_nxt = qevt_clamp(sum, cfg.min_value, cfg.max_value);
              if ({1'b0, cur_value_nxt} != last_sent_r) begin
                pending_nxt = 1'b1;
              end
            end else begin
              acc_nxt = q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r     <= 1'b0;
      last_phase_r  <= '0;
      acc_r         <= Q_NONE;
      cur_value_r   <= '0;
      last_sent_r   <= NoneSent;
      pending_r     <= 1'b1;
      lock_raw_r    <= 1'b0;
      lock_stable_r <= 1'b0;
      lock_chg_r    <= '0;
      suppress_r    <= '0;
      last_us_r     <= '0;
      blocked_r     <= 1'b0;
    end else begin
      started_r     <= started_nxt;
      last_phase_r  <= last_phase_nxt;
      acc_r         <= acc_nxt;
      cur_value_r   <= cur_value_nxt;
      last_sent_r   <= last_sent_nxt;
      pending_r     <= pending_nxt;
      lock_raw_r    <= lock_raw_nxt;
      lock_stable_r <= lock_stable_nxt;
      lock_chg_r    <= lock_chg_nxt;
      suppress_r    <= suppress_nxt;
      last_us_r     <= last_us_nxt;
      blocked_r     <= blocked_nxt;
    end
  end

  assign result.msg_valid    = msg_valid;
  assign result.msg_value    = cur_value_nxt;
  assign result.pending_flag = pending_nxt;
  assign result.locked       = blocked_nxt;

endmodule

// ----- rtl/quadrature_encoder_value_tracker.sv -----
// ---------------------------------------------------------------------------
// quadrature_encoder_value_tracker: quadrature encoder value tracker
// Decodes A/B pin samples into a clamped value with lock and read-out.
// ---------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low: an item is
// transferred on the input channel when in_valid is high and in_stall is
// low, lands in an input register, and once the result register is free or
// draining, one pass of decode logic updates the tracker state and loads the
// result register, so every item gives exactly one result. The single decode
// pass holds lock debounce compares, a 32-bit gap compare, and one small add
// with clamp. in_stall rises only while the result register holds an
// untaken result and the input register is full. A pin sample (req_type 0)
// moves the value by the sensitivity register (zero counts as one) on every
// second quarter-step in one direction; a read request (req_type 1) reports
// msg_valid and clears the pending flag when a changed value waits or
// nothing has been read out since reset. Configuration goes through the cfg_
// port, which is always ready, and must be written only while the block is idle.
// ---------------------------------------------------------------------------
module quadrature_encoder_value_tracker import qevt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic                 in_pin_a,
  input  logic                 in_pin_b,
  input  logic                 in_lock_low,
  input  logic [31:0]          in_now_us,
  input  logic [31:0]          in_now_ms,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_msg_valid,
  output logic [6:0]           out_msg_value,
  output logic                 out_pending_flag,
  output logic                 out_locked,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  qevt_cfg_t    cfg;
  logic         range_upd;

  qevt_item_t   item_r;
  logic         item_valid_r;
  qevt_result_t step_res;
  qevt_result_t res_r;
  logic         res_valid_r;

  logic         advance;
  logic         in_xfer;

  // Advance the held item whenever the result register is free or draining.
  assign advance  = item_valid_r && (!res_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;

  assign cfg_ready = 1'b1;

  qevt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .cfg       (cfg),
    .range_upd (range_upd)
  );

  // Input register: capture each transfer, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_xfer) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.req_type <= qevt_req_t'(in_req_type);
      item_r.pin_a    <= in_pin_a;
      item_r.pin_b    <= in_pin_b;
      item_r.lock_low <= in_lock_low;
      item_r.now_us   <= in_now_us;
      item_r.now_ms   <= in_now_ms;
    end
  end

  // An item's step commits only as it moves into the result register.
  qevt_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .range_upd (range_upd),
    .step_en   (advance),
    .item      (item_r),
    .result    (step_res)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (!out_stall) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_msg_valid    = res_r.msg_valid;
  assign out_msg_value    = res_r.msg_value;
  assign out_pending_flag = res_r.pending_flag;
  assign out_locked       = res_r.locked;

endmodule

// ----- rtl/qevt_checker.sv -----
// ---------------------------------------------------------------------------
// qevt_checker: port-level checks of the value tracker
// Watches the top-level ports; bound to the top level below.
// ---------------------------------------------------------------------------
module qevt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_msg_valid,
  input logic [6:0] out_msg_value,
  input logic       out_pending_flag,
  input logic       out_locked
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Input never stalls while the result side can take a transfer.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled with free result register");

  // A read that hands out a value leaves nothing pending.
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_msg_valid) |-> !out_pending_flag)
    else $error("pending still set after read-out");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_msg_value) && $stable(out_msg_valid)
       && $stable(out_pending_flag) && $stable(out_locked)))
    else $error("stalled result changed");

endmodule

bind quadrature_encoder_value_tracker qevt_checker u_qevt_checker (.*);
